>>> src/pid_time_proportioning_relay_defines.svh
// Assertion macros for the PID relay block
`ifndef PID_TIME_PROPORTIONING_RELAY_DEFINES_SVH
`define PID_TIME_PROPORTIONING_RELAY_DEFINES_SVH
// assert that a implies b on the same edge
`define PTR_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("lbl failed");
// assert that a implies b on the next edge
`define PTR_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("lbl failed");
`endif

>>> src/ptr_pkg.sv
// Package: widths, constants, controller codes and command types
`timescale 1ns / 1ps
package ptr_pkg;
  localparam int TB = 16;
  localparam logic [TB-1:0] TMAX = {TB{1'b1}};
  localparam logic [14:0] FS_Q8 = 15'd25600;
  localparam logic signed [23:0] INTEG_MAX = 24'sd8388607;
  localparam logic [2:0] CFG_SP = 3'd0, CFG_KP = 3'd1, CFG_KI = 3'd2, CFG_KD = 3'd3,
    CFG_PER = 3'd4, CFG_WIN = 3'd5, CFG_TOG = 3'd6;
  localparam logic [2:0] OP_COUNT = 3'd0, OP_MULP = 3'd1, OP_MULI = 3'd2, OP_MULD = 3'd3,
    OP_DRIVE = 3'd4, OP_RELAY = 3'd5, OP_LIMIT = 3'd6;
  typedef struct packed {
    logic       go;
    logic [2:0] op;
  } cmd_t;
  typedef struct packed {
    logic step;
    logic lim_busy;
  } stat_t;
endpackage

>>> src/pid_time_proportioning_relay.sv
// Top level: PID controller with time-proportioning relay output
//  channel | dir | fields (tdata, low bit first)
//  in      | in  | temp_sixteenths[11:0], temp_valid, clear_pid
//  out     | out | relay_on, drive_q8[14:0], sample_taken
//  cfg     | in  | write port, 3-bit index, 18-bit data
// A PID step adds the multiply and drive states to an item; the shared
// 18x25 multiplier runs three times per step. Results leave through an
// output register. After a nonzero write of ki_dt_gain a divider works out
// the integral limit and no item is taken meanwhile. Reset is synchronous.
`timescale 1ns / 1ps
`include "pid_time_proportioning_relay_defines.svh"
module pid_time_proportioning_relay (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // temp_sixteenths[11:0], temp_valid, clear_pid
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // relay_on, drive_q8[14:0], sample_taken
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [17:0] cfg_wdata
);
  import ptr_pkg::*;
  cmd_t cmd;
  stat_t stat;
  logic busy, done, done_r, relay, sampled, ov_r;
  logic [14:0] drive;
  logic [15:0] hold_r;
  logic [15:0] tick_d;
  logic [23:0] od_r;
  assign in_tready = !busy;
  always_ff @(posedge clk) if (in_tvalid && in_tready) hold_r <= in_tdata;
  // the item is counted on its accepting edge, so read it from the port there
  assign tick_d = (in_tvalid && in_tready) ? in_tdata : hold_r;
  ptr_ctrl u_ctrl (.clk, .rst_n, .in_fire(in_tvalid && in_tready),
    .out_free(!ov_r || out_tready), .stat, .cmd, .busy, .done);
  ptr_dp u_dp (.clk, .rst_n, .cmd, .stat, .cfg_we, .cfg_idx, .cfg_wdata,
    .temp_i($signed(tick_d[11:0])), .valid_i(tick_d[12]), .clear_i(tick_d[13]),
    .relay_o(relay), .drive_o(drive), .sampled_o(sampled));
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      done_r <= done;
      if (done_r) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) if (done_r) od_r <= {7'd0, sampled, drive, relay};
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  `PTR_ASSERT_IMP(a_no_accept_busy, busy, !in_tready)
  `PTR_ASSERT_NEXT(a_done_valid, done_r, out_tvalid)
  `PTR_ASSERT_IMP(a_drive_range, out_tvalid, out_tdata[15:1] <= FS_Q8)
endmodule

>>> src/ptr_ctrl.sv
// Controller: sequences one tick through the datapath
`timescale 1ns / 1ps
module ptr_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           out_free,
  input  ptr_pkg::stat_t stat,
  output ptr_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done
);
  import ptr_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_MP = 3'd1, S_MI = 3'd2, S_MD = 3'd3,
    S_DRV = 3'd4, S_REL = 3'd5, S_WAIT = 3'd6;
  logic [2:0] st_r, st_nxt;
  always_comb begin
    st_nxt = st_r;
    cmd.go = 1'b0;
    cmd.op = OP_COUNT;
    done = 1'b0;
    case (st_r)
      S_IDLE: if (in_fire) begin
        cmd.go = 1'b1; cmd.op = OP_COUNT; st_nxt = S_MP;
      end
      S_MP: begin
        if (stat.step) begin cmd.go = 1'b1; cmd.op = OP_MULP; st_nxt = S_MI; end
        else st_nxt = S_REL;
      end
      S_MI: begin cmd.go = 1'b1; cmd.op = OP_MULI; st_nxt = S_MD; end
      S_MD: begin cmd.go = 1'b1; cmd.op = OP_MULD; st_nxt = S_DRV; end
      S_DRV: begin cmd.go = 1'b1; cmd.op = OP_DRIVE; st_nxt = S_REL; end
      S_REL: if (out_free) begin
        cmd.go = 1'b1; cmd.op = OP_RELAY; done = 1'b1; st_nxt = S_WAIT;
      end
      S_WAIT: if (!stat.lim_busy) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end
  assign busy = (st_r != S_IDLE) || stat.lim_busy;
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

>>> src/ptr_dp.sv
// Datapath: counters, PID multiply-accumulate, limit divider and relay logic
`timescale 1ns / 1ps
module ptr_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ptr_pkg::cmd_t       cmd,
  output ptr_pkg::stat_t      stat,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_idx,
  input  logic [17:0]         cfg_wdata,
  input  logic signed [11:0]  temp_i,
  input  logic                valid_i,
  input  logic                clear_i,
  output logic                relay_o,
  output logic [14:0]         drive_o,
  output logic                sampled_o
);
  import ptr_pkg::*;
  logic signed [9:0] sp_r;
  logic [17:0] kp_r, ki_r, kd_r;
  logic [15:0] per_r, win_r, tog_r;
  logic signed [23:0] lim_r, integ_r;
  logic signed [12:0] prev_r, e_r;
  logic [14:0] drive_r;
  logic [TB-1:0] tss_r, pos_r, tst_r;
  logic relay_r, step_r, sampled_r;
  logic signed [47:0] acc_r;
  // restoring divider for the integral limit
  logic [22:0] q_r, rem_r;
  logic [4:0] dcnt_r;
  logic dbusy_r;
  logic fin_r;
  localparam logic [22:0] DIVIDEND = 23'd6553600;

  logic signed [12:0] e_c;
  logic [TB-1:0] tss_b, pos_b, tst_b;
  logic signed [24:0] isum;
  logic signed [23:0] inew;
  logic signed [18:0] mop;
  logic signed [24:0] mx;
  logic signed [44:0] prod;
  logic [23:0] rtrial;
  logic [TB+15:0] lhs, rhs;
  logic want;
  logic relay_nx;

  assign tss_b = (tss_r == TMAX) ? TMAX : tss_r + 1'b1;
  assign pos_b = (pos_r == TMAX) ? TMAX : pos_r + 1'b1;
  assign tst_b = (tst_r == TMAX) ? TMAX : tst_r + 1'b1;
  assign e_c = 13'(temp_i) - 13'(sp_r);
  assign isum = 25'(integ_r) + 25'(e_r);
  always_comb begin
    if (isum > 25'(lim_r)) inew = lim_r;
    else if (isum < -25'(lim_r)) inew = -lim_r;
    else inew = isum[23:0];
  end
  always_comb begin
    case (cmd.op)
      OP_MULI: begin mop = $signed({1'b0, ki_r}); mx = 25'(integ_r); end
      OP_MULD: begin mop = $signed({1'b0, kd_r}); mx = 25'(e_r) - 25'(prev_r); end
      default: begin mop = $signed({1'b0, kp_r}); mx = 25'(e_r); end
    endcase
  end
  assign prod = mop * mx;
  assign rtrial = {rem_r, DIVIDEND[5'd22 - dcnt_r]};
  assign lhs = (TB+16)'(pos_r + 1'b1) * (TB+16)'(FS_Q8);
  assign rhs = (TB+16)'(drive_r) * (TB+16)'(win_r);
  assign want = ({1'b0, lhs} <= {1'b0, rhs}) && (pos_r != TMAX || win_r != 16'd0);
  // relay decision in the cycle after the wrap
  assign relay_nx = (fin_r && want != relay_r && (tst_r >= TB'(tog_r) || tst_r == TMAX)) ?
    want : relay_r;
  assign stat.step = step_r;
  assign stat.lim_busy = dbusy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= 10'sd128; kp_r <= 18'd81920; ki_r <= 18'd246; kd_r <= 18'd122880;
      per_r <= 16'd2000; win_r <= 16'd60000; tog_r <= 16'd10000;
      lim_r <= 24'sd26640; dbusy_r <= 1'b0; dcnt_r <= '0; q_r <= '0; rem_r <= '0;
      integ_r <= '0; prev_r <= '0; drive_r <= '0; tss_r <= '0; pos_r <= '0;
      tst_r <= '0; relay_r <= 1'b0; step_r <= 1'b0; sampled_r <= 1'b0;
      e_r <= '0; acc_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SP:  sp_r <= cfg_wdata[9:0];
          CFG_KP:  kp_r <= cfg_wdata;
          CFG_KI: begin
            ki_r <= cfg_wdata;
            if (cfg_wdata == 18'd0) lim_r <= INTEG_MAX;
            else begin dbusy_r <= 1'b1; dcnt_r <= '0; q_r <= '0; rem_r <= '0; end
          end
          CFG_KD:  kd_r <= cfg_wdata;
          CFG_PER: per_r <= cfg_wdata[15:0];
          CFG_WIN: win_r <= cfg_wdata[15:0];
          CFG_TOG: tog_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (dbusy_r) begin
        if (rtrial >= {6'd0, ki_r}) begin
          rem_r <= 23'(rtrial - {6'd0, ki_r}); q_r <= {q_r[21:0], 1'b1};
        end else begin
          rem_r <= rtrial[22:0]; q_r <= {q_r[21:0], 1'b0};
        end
        dcnt_r <= dcnt_r + 1'b1;
        if (dcnt_r == 5'd22) begin
          dbusy_r <= 1'b0;
          lim_r <= $signed({1'b0, q_r[21:0], (rtrial >= {6'd0, ki_r})});
        end
      end
      if (cmd.go) begin
        case (cmd.op)
          OP_COUNT: begin
            tst_r <= tst_b;
            step_r <= 1'b0;
            sampled_r <= 1'b0;
            e_r <= e_c;
            if (clear_i) begin
              integ_r <= '0; prev_r <= '0; drive_r <= '0; tss_r <= '0; pos_r <= '0;
            end else begin
              pos_r <= pos_b;
              if (!valid_i) begin
                drive_r <= '0; tss_r <= TMAX;
              end else if (tss_b >= TB'(per_r) || tss_b == TMAX) begin
                step_r <= 1'b1; tss_r <= '0;
              end else tss_r <= tss_b;
            end
          end
          OP_MULP: begin acc_r <= 48'(prod); integ_r <= inew; end
          OP_MULI: acc_r <= acc_r + 48'(prod);
          OP_MULD: acc_r <= acc_r + 48'(prod);
          OP_DRIVE: begin
            if (acc_r <= 0) drive_r <= '0;
            else if (acc_r[47:8] > 40'(FS_Q8)) drive_r <= FS_Q8;
            else drive_r <= acc_r[22:8];
            prev_r <= e_r;
            sampled_r <= 1'b1;
          end
          OP_RELAY: begin
            if (!clear_i && pos_r >= TB'(win_r)) pos_r <= pos_r - TB'(win_r);
          end
          default: ;
        endcase
      end
      if (relay_nx != relay_r) begin
        relay_r <= relay_nx; tst_r <= '0;
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) fin_r <= 1'b0;
    else fin_r <= cmd.go && cmd.op == OP_RELAY;
  end
  assign relay_o = relay_nx;
  assign drive_o = drive_r;
  assign sampled_o = sampled_r;
endmodule
